>>> hw/rtl/sitdt_pkg.sv
package sitdt_pkg;

    // ASCII codes, truncated to the 6-bit character field
    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_FIND,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input beat, start conversion
        logic shift;       // one double-dabble step
        logic find;        // locate leading nonzero digit
        logic sel_sign;    // present '-' on the output
        logic emit_digit;  // digit beat taken, step to next digit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic shift_done;  // current shift is the final one
        logic negative;
        logic ptr_zero;    // pointing at the least significant digit
    } status_t;

endpackage

>>> hw/rtl/sitdt_datapath.sv
module sitdt_datapath #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sitdt_pkg::cmd_t         cmd,
    input  logic [VALUE_WIDTH-1:0]  value,
    output sitdt_pkg::status_t      status,
    output logic [5:0]              char_code,
    output logic                    last
);

    // enough BCD digits for 2^(VALUE_WIDTH-1)
    localparam int NDIG = (VALUE_WIDTH * 3 + 9) / 10;
    localparam int PW   = $clog2(NDIG);
    localparam int CW   = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic [NDIG-1:0][3:0]    bcd_reg, bcd_next;
    logic [NDIG-1:0][3:0]    bcd_adj;
    logic [NDIG*4-1:0]       bcd_flat;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [PW-1:0]           ptr_reg, ptr_next;
    logic [PW-1:0]           top_idx;
    logic                    neg_reg, neg_next;
    logic [3:0]              cur_digit;

    // add-3 correction, independent per digit
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i] >= 4'd5)
            begin
                bcd_adj[i] = bcd_reg[i] + 4'd3;
            end
            else
            begin
                bcd_adj[i] = bcd_reg[i];
            end
        end
    end

    assign bcd_flat = bcd_adj;

    // highest nonzero digit, zero if none
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top_idx = PW'(i);
            end
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        neg_next = neg_reg;
        if (cmd.load)
        begin
            neg_next = value[VALUE_WIDTH-1];
            mag_next = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
            bcd_next = '0;
            cnt_next = CW'(VALUE_WIDTH - 1);
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_flat[NDIG*4-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
        else if (cmd.find)
        begin
            ptr_next = top_idx;
        end
        else if (cmd.emit_digit)
        begin
            ptr_next = ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign cur_digit = bcd_reg[ptr_reg];

    assign status.shift_done = (cnt_reg == '0);
    assign status.negative   = neg_reg;
    assign status.ptr_zero   = (ptr_reg == '0);

    assign char_code = cmd.sel_sign ? sitdt_pkg::CH_MINUS
                                    : sitdt_pkg::CH_ZERO + {2'b00, cur_digit};
    assign last      = !cmd.sel_sign && (ptr_reg == '0);

endmodule

>>> hw/rtl/sitdt_controller.sv
module sitdt_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  sitdt_pkg::status_t  status,
    output sitdt_pkg::cmd_t     cmd
);

    sitdt_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sitdt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sitdt_pkg::ST_CONVERT;
                end
            end
            sitdt_pkg::ST_CONVERT:
            begin
                if (status.shift_done)
                begin
                    state_next = sitdt_pkg::ST_FIND;
                end
            end
            sitdt_pkg::ST_FIND:
            begin
                state_next = status.negative ? sitdt_pkg::ST_SIGN : sitdt_pkg::ST_DIGITS;
            end
            sitdt_pkg::ST_SIGN:
            begin
                if (!out_stall)
                begin
                    state_next = sitdt_pkg::ST_DIGITS;
                end
            end
            sitdt_pkg::ST_DIGITS:
            begin
                if (!out_stall && status.ptr_zero)
                begin
                    state_next = sitdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            sitdt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            sitdt_pkg::ST_CONVERT:
            begin
                cmd.shift = 1'b1;
            end
            sitdt_pkg::ST_FIND:
            begin
                cmd.find = 1'b1;
            end
            sitdt_pkg::ST_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            sitdt_pkg::ST_DIGITS:
            begin
                out_valid      = 1'b1;
                cmd.emit_digit = !out_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/signed_integer_to_decimal_text_unit.sv
// Signed integer to decimal ASCII text.
//
// Input channel (in_valid / in_stall): one beat carries a two's complement
// value. Output channel (out_valid / out_stall): one beat per character,
// most significant first, '-' leading for negative values, no leading
// zeros, zero gives "0"; last marks the final character of the number.
//
// Operation: the magnitude goes through a double-dabble BCD converter, one
// bit per cycle, and the leading nonzero digit is then located.
// Characters then leave at one per cycle while the receiver does not stall.
//
// in_stall stays high from the accepting edge until the last character
// beat is taken. A stall on the output holds char_code and last steady.
// Reset returns the controller to idle; no characters are pending after.
module signed_integer_to_decimal_text_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [VALUE_WIDTH-1:0]  value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [5:0]              char_code,
    output logic                    last
);

    sitdt_pkg::cmd_t    cmd;
    sitdt_pkg::status_t status;

    // sequencing: idle / convert / find leading digit / sign / digits
    sitdt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // magnitude, BCD shift register, digit pointer, character mux
    sitdt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .status    (status),
        .char_code (char_code),
        .last      (last)
    );

endmodule

>>> hw/rtl/sitdt_checker.sv
module sitdt_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [VALUE_WIDTH-1:0]  value,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [5:0]              char_code,
    input logic                    last
);

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value))
        else $error("stalled input beat changed");

    // stalled character beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
        else $error("stalled output beat changed");

    // no new number is taken while characters are pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while emitting");

    // the final character is always a digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> char_code >= sitdt_pkg::CH_ZERO &&
                              char_code <= sitdt_pkg::CH_ZERO + 6'd9)
        else $error("last beat is not a digit");

    // a sign beat is followed at once by a digit beat
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && char_code == sitdt_pkg::CH_MINUS
        |=> out_valid && char_code != sitdt_pkg::CH_MINUS)
        else $error("sign not followed by a digit");

endmodule

bind signed_integer_to_decimal_text_unit sitdt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_sitdt_checker (.*);
